// ===== rtl/arabic_contextual_shaper_core_assert.svh =====
// Assertion macros for the shaper core.
`ifndef ARABIC_CONTEXTUAL_SHAPER_CORE_ASSERT_SVH
`define ARABIC_CONTEXTUAL_SHAPER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ACS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ACS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ACS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/acs_pkg.sv =====
package acs_pkg;

    localparam int CP_W = 21;

    typedef logic [CP_W-1:0] t_cp;

    localparam logic [2:0] J_U = 3'd0;
    localparam logic [2:0] J_R = 3'd1;
    localparam logic [2:0] J_D = 3'd2;
    localparam logic [2:0] J_C = 3'd3;
    localparam logic [2:0] J_T = 3'd4;

    localparam t_cp CP_LAM     = 21'h000644;
    localparam t_cp CP_HAMZA   = 21'h000621;
    localparam t_cp CP_YEH     = 21'h00064A;
    localparam t_cp CP_AE      = 21'h0006D5;
    localparam t_cp CP_ZWJ     = 21'h00200D;
    localparam t_cp CP_TATWEEL = 21'h000640;
    localparam t_cp CP_ZWNJ    = 21'h00200C;
    localparam t_cp LIG_MADDA  = 21'h00FEF5;
    localparam t_cp LIG_PLAIN  = 21'h00FEFB;
    localparam t_cp FORM_BASE  = 21'h00FE80;
    localparam t_cp PERS_PEH   = 21'h00FB56;
    localparam t_cp PERS_YEH   = 21'h00FBFC;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;      // latch the accepted transaction
        logic emit_sel;  // 0: first result, 1: buffered mark or trailing point
        logic mark_adv;  // advance the mark read pointer
        logic commit;    // apply the state update of the transaction
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic has_first;  // the transaction gives a first result
        logic marks_left; // buffered marks or the trailing point remain to be emitted
        logic last_mark;  // current mark or trailing point is the final result
    } t_sts;

    function automatic logic is_mark(t_cp c);
        return (c >= 21'h0591 && c <= 21'h05BD) || c == 21'h05BF || c == 21'h05C1 ||
               c == 21'h05C2 || c == 21'h05C4 || c == 21'h05C5 || c == 21'h05C7 ||
               (c >= 21'h064B && c <= 21'h065F) || c == 21'h0670 ||
               (c >= 21'h06D6 && c <= 21'h06DC) || (c >= 21'h06DF && c <= 21'h06E4) ||
               c == 21'h06E7 || c == 21'h06E8 || (c >= 21'h06EA && c <= 21'h06ED) ||
               (c >= 21'h08D3 && c <= 21'h08FF) || (c >= 21'hFE70 && c <= 21'hFE7F);
    endfunction

    function automatic logic is_right(t_cp c);
        logic r;
        r = 1'b0;
        case (c)
            21'h0622, 21'h0623, 21'h0624, 21'h0625, 21'h0627, 21'h0629, 21'h062F,
            21'h0630, 21'h0631, 21'h0632, 21'h0648, 21'h0649, 21'h0671, 21'h0672,
            21'h0673, 21'h0675, 21'h06C0, 21'h06D2, 21'h06D3, 21'h06D5: r = 1'b1;
            default: r = (c >= 21'h0688 && c <= 21'h0699);
        endcase
        return r;
    endfunction

    function automatic logic [2:0] classify(t_cp c);
        logic [2:0] j;
        if ((c >= 21'hFB50 && c <= 21'hFDFF) || (c >= 21'hFE70 && c <= 21'hFEFF)) begin
            j = J_U;
        end else if (is_mark(c)) begin
            j = J_T;
        end else if (c == CP_ZWNJ) begin
            j = J_U;
        end else if (c == CP_ZWJ || c == CP_TATWEEL) begin
            j = J_C;
        end else if (c < CP_HAMZA || c > CP_AE) begin
            j = ((c >= 21'h0750 && c <= 21'h077F) || (c >= 21'h08A0 && c <= 21'h08D2))
                ? J_D : J_U;
        end else if (c == CP_HAMZA) begin
            j = J_U;
        end else if (is_right(c)) begin
            j = J_R;
        end else begin
            j = J_D;
        end
        return j;
    endfunction

    // Forms of the basic block and six extra letters; f: 0 isolated, 1 final, 2 initial, 3 medial.
    function automatic t_cp shaped(t_cp c, logic [1:0] f);
        logic [5:0] idx;
        logic [15:0] v;
        logic [15:0] first;
        logic n2;
        logic n4;
        idx = c[5:0] - 6'h21;
        v = 16'h0;
        if (c >= CP_HAMZA && c <= CP_YEH) begin
            // Slots per letter: hamza 1, two-form letters 2, four-form 4.
            n2 = 1'b0;
            n4 = 1'b0;
            case (idx)
                6'd0: first = 16'hFE80;
                6'd1: begin first = 16'hFE81; n2 = 1'b1; end
                6'd2: begin first = 16'hFE83; n2 = 1'b1; end
                6'd3: begin first = 16'hFE85; n2 = 1'b1; end
                6'd4: begin first = 16'hFE87; n2 = 1'b1; end
                6'd5: begin first = 16'hFE89; n4 = 1'b1; end
                6'd6: begin first = 16'hFE8D; n2 = 1'b1; end
                6'd7: begin first = 16'hFE8F; n4 = 1'b1; end
                6'd8: begin first = 16'hFE93; n2 = 1'b1; end
                6'd9: begin first = 16'hFE95; n4 = 1'b1; end
                6'd10: begin first = 16'hFE99; n4 = 1'b1; end
                6'd11: begin first = 16'hFE9D; n4 = 1'b1; end
                6'd12: begin first = 16'hFEA1; n4 = 1'b1; end
                6'd13: begin first = 16'hFEA5; n4 = 1'b1; end
                6'd14: begin first = 16'hFEA9; n2 = 1'b1; end
                6'd15: begin first = 16'hFEAB; n2 = 1'b1; end
                6'd16: begin first = 16'hFEAD; n2 = 1'b1; end
                6'd17: begin first = 16'hFEAF; n2 = 1'b1; end
                6'd18: begin first = 16'hFEB1; n4 = 1'b1; end
                6'd19: begin first = 16'hFEB5; n4 = 1'b1; end
                6'd20: begin first = 16'hFEB9; n4 = 1'b1; end
                6'd21: begin first = 16'hFEBD; n4 = 1'b1; end
                6'd22: begin first = 16'hFEC1; n4 = 1'b1; end
                6'd23: begin first = 16'hFEC5; n4 = 1'b1; end
                6'd24: begin first = 16'hFEC9; n4 = 1'b1; end
                6'd25: begin first = 16'hFECD; n4 = 1'b1; end
                6'd32: begin first = 16'hFED1; n4 = 1'b1; end
                6'd33: begin first = 16'hFED5; n4 = 1'b1; end
                6'd34: begin first = 16'hFED9; n4 = 1'b1; end
                6'd35: begin first = 16'hFEDD; n4 = 1'b1; end
                6'd36: begin first = 16'hFEE1; n4 = 1'b1; end
                6'd37: begin first = 16'hFEE5; n4 = 1'b1; end
                6'd38: begin first = 16'hFEE9; n4 = 1'b1; end
                6'd39: begin first = 16'hFEED; n2 = 1'b1; end
                6'd40: begin first = 16'hFEEF; n2 = 1'b1; end
                6'd41: begin first = 16'hFEF1; n4 = 1'b1; end
                default: first = 16'h0;
            endcase
            if (n4) begin
                v = first + {14'h0, f};
            end else if (n2 && f == 2'd1) begin
                v = first + 16'd1;
            end else begin
                v = first;
            end
        end else begin
            first = 16'h0;
            n2 = 1'b0;
            n4 = 1'b1;
            case (c)
                21'h067E: first = PERS_PEH[15:0];
                21'h0686: first = 16'hFB7A;
                21'h0698: begin first = 16'hFB8A; n4 = 1'b0; end
                21'h06A9: first = 16'hFB8E;
                21'h06AF: first = 16'hFB92;
                21'h06CC: first = PERS_YEH[15:0];
                default: first = 16'h0;
            endcase
            if (first != 16'h0) begin
                v = (n4 || f == 2'd1) ? first + {14'h0, f} : first;
            end
        end
        return (v != 16'h0) ? {5'h0, v} : c;
    endfunction

    function automatic t_cp ligature(t_cp alef, logic joined);
        t_cp b;
        case (alef)
            21'h0622: b = LIG_MADDA;
            21'h0623: b = LIG_MADDA + 21'd2;
            21'h0625: b = LIG_MADDA + 21'd4;
            21'h0627: b = LIG_PLAIN;
            default: b = '0;
        endcase
        return (b == '0) ? '0 : b + {20'h0, joined};
    endfunction

endpackage

// ===== rtl/acs_if.sv =====
interface acs_in_if;
    logic                 valid;
    logic                 ready;
    acs_pkg::t_cp         code_point;
    logic                 string_end;
    modport source (output valid, output code_point, output string_end, input ready);
    modport sink (input valid, input code_point, input string_end, output ready);
endinterface

interface acs_out_if;
    logic                 valid;
    logic                 ready;
    acs_pkg::t_cp         shaped_point;
    logic                 run_end;
    logic                 string_done;
    logic                 marks_dropped;
    modport source (output valid, output shaped_point, output run_end, output string_done,
                    output marks_dropped, input ready);
    modport sink (input valid, input shaped_point, input run_end, input string_done,
                  input marks_dropped, output ready);
endinterface

// ===== rtl/acs_datapath.sv =====
`include "arabic_contextual_shaper_core_assert.svh"

module acs_datapath #(
    parameter int MARK_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acs_pkg::t_cp      i_code_point,
    input  logic              i_string_end,
    input  acs_pkg::t_cmd     i_cmd,
    output acs_pkg::t_sts     o_sts,
    output acs_pkg::t_cp      o_point,
    output logic              o_end,
    output logic              o_dropped
);

    localparam int AW = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;
    localparam int CW = $clog2(MARK_SLOTS + 1);

    logic [acs_pkg::CP_W-1:0] mem [MARK_SLOTS];
    acs_pkg::t_cp r_cp, r_pend_cp, r_first, r_mark;
    logic r_end, r_pend_v, r_pend_jb, r_prev_join, r_ovf, r_has_first, r_dropped;
    logic [CW-1:0] r_cnt, r_drain_n, r_rd;
    acs_pkg::t_cp r_self;
    logic r_self_after;

    // Decode of the latched transaction
    logic [2:0] jt;
    logic resolve, lig_used, buf_mark, n_pend_v, n_prev_join, n_ovf, has_first;
    logic [1:0] f_pend;
    acs_pkg::t_cp lig, first, n_pend_cp;
    logic n_pend_jb;
    logic [CW-1:0] drain_n, n_cnt;

    always_comb begin
        jt        = acs_pkg::classify(r_cp);
        lig       = acs_pkg::ligature(r_cp, r_pend_jb);
        f_pend    = {(jt != acs_pkg::J_U && jt != acs_pkg::J_T), r_pend_jb};
        n_pend_v  = r_pend_v;
        n_pend_cp = r_pend_cp;
        n_pend_jb = r_pend_jb;
        n_prev_join = r_prev_join;
        n_ovf     = r_ovf;
        n_cnt     = r_cnt;
        drain_n   = '0;
        has_first = 1'b0;
        first     = r_cp;
        resolve   = 1'b0;
        lig_used  = 1'b0;
        buf_mark  = 1'b0;
        if (jt == acs_pkg::J_T) begin
            if (r_pend_v) begin
                has_first = 1'b0;
                if (r_cnt < CW'(MARK_SLOTS)) begin
                    buf_mark = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                if (r_end) begin
                    // flush the waiting point as not joined forward
                    resolve   = 1'b1;
                    has_first = 1'b1;
                    first     = acs_pkg::shaped(r_pend_cp, {1'b0, r_pend_jb});
                    drain_n   = n_cnt;
                end
            end else begin
                has_first = 1'b1;
            end
        end else begin
            if (r_pend_v) begin
                resolve = 1'b1;
                has_first = 1'b1;
                drain_n = r_cnt;
                if (r_pend_cp == acs_pkg::CP_LAM && f_pend[1] && lig != '0) begin
                    lig_used = 1'b1;
                    first = lig;
                    n_prev_join = 1'b0;
                end else begin
                    first = acs_pkg::shaped(r_pend_cp, f_pend);
                    n_prev_join = 1'b1;
                end
                n_pend_v = 1'b0;
                n_pend_cp = '0;
                n_pend_jb = 1'b0;
                n_cnt = '0;
            end
        end
        if (resolve && jt == acs_pkg::J_T) begin
            n_pend_v = 1'b0;
        end
    end

    // Second part: the current point itself, following any resolved point.
    acs_pkg::t_cp self_pt;
    logic self_emit, self_wait, n_prev2;
    always_comb begin
        self_emit = 1'b0;
        self_wait = 1'b0;
        self_pt   = r_cp;
        n_prev2   = n_prev_join;
        if (jt != acs_pkg::J_T && !lig_used) begin
            if (jt == acs_pkg::J_U) begin
                self_emit = 1'b1;
                self_pt = acs_pkg::shaped(r_cp, 2'd0);
                n_prev2 = 1'b0;
            end else if (jt == acs_pkg::J_R || r_end) begin
                self_emit = 1'b1;
                self_pt = acs_pkg::shaped(r_cp, {1'b0, n_prev_join});
                n_prev2 = (jt != acs_pkg::J_R);
            end else begin
                self_wait = 1'b1;
            end
        end
    end

    // Results of one transaction: first, marks, then the current point.
    // The current point is shown as a final step of the mark phase, from r_self.
    logic self_after;
    assign self_after = resolve && self_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_pend_jb <= 1'b0;
            r_prev_join <= 1'b0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
            r_drain_n <= '0;
            r_rd <= '0;
            r_has_first <= 1'b0;
            r_pend_cp <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cp <= i_code_point;
                r_end <= i_string_end;
            end
            if (buf_mark && i_cmd.commit) begin
                mem[r_cnt[AW-1:0]] <= r_cp;
            end
            if (i_cmd.commit) begin
                r_has_first <= has_first || self_emit;
                r_first <= resolve ? first : (self_emit ? self_pt : r_cp);
                r_self <= self_pt;
                r_self_after <= self_after;
                r_drain_n <= drain_n;
                r_rd <= '0;
                r_dropped <= n_ovf;
                if (r_end) begin
                    r_pend_v <= 1'b0;
                    r_pend_cp <= '0;
                    r_pend_jb <= 1'b0;
                    r_prev_join <= 1'b0;
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_pend_v <= self_wait ? 1'b1 : n_pend_v;
                    r_pend_cp <= self_wait ? r_cp : n_pend_cp;
                    r_pend_jb <= self_wait ? n_prev_join : n_pend_jb;
                    r_prev_join <= n_prev2;
                    r_cnt <= n_cnt;
                    r_ovf <= n_ovf;
                end
            end else if (i_cmd.mark_adv) begin
                r_rd <= r_rd + CW'(1);
            end
        end
    end

    // Registered read of the mark store; past the count, the trailing point.
    logic [AW-1:0] rd_addr;
    assign rd_addr = (i_cmd.mark_adv && !i_cmd.commit) ? AW'(r_rd + CW'(1)) : AW'(r_rd);
    always_ff @(posedge i_clk) begin
        r_mark <= mem[rd_addr];
    end

    logic in_marks;
    assign in_marks = (r_rd < r_drain_n);
    assign o_sts.has_first  = r_has_first;
    assign o_sts.marks_left = in_marks || (r_self_after && r_rd == r_drain_n);
    assign o_sts.last_mark  = r_self_after ? (r_rd == r_drain_n)
                                            : (r_rd + CW'(1) == r_drain_n);
    assign o_point   = i_cmd.emit_sel ? (in_marks ? r_mark : r_self) : r_first;
    assign o_end     = r_end;
    assign o_dropped = r_dropped;

    `ACS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MARK_SLOTS),
        "mark count beyond buffer")
    `ACS_ASSERT_IMP(a_marks_need_pend, i_clk, i_rst_n, r_cnt != '0, r_pend_v,
        "marks buffered with no waiting point")
    `ACS_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_cmd.commit && r_end,
        !r_pend_v && r_cnt == '0 && !r_ovf, "state kept past string end")

endmodule

// ===== rtl/acs_ctrl.sv =====
`include "arabic_contextual_shaper_core_assert.svh"

module acs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_run_end,
    input  acs_pkg::t_sts i_sts,
    output acs_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_run_end = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                // the wait state lets the registered mark read land
                n_state = !i_sts.has_first ? S_IDLE : S_FIRST;
            end
            S_FIRST: begin
                o_out_valid = 1'b1;
                o_run_end = !i_sts.marks_left;
                if (i_out_ready) begin
                    n_state = i_sts.marks_left ? S_MARK : S_IDLE;
                end
            end
            S_MARK: begin
                o_out_valid = 1'b1;
                o_cmd.emit_sel = 1'b1;
                o_run_end = i_sts.last_mark;
                if (i_out_ready) begin
                    o_cmd.mark_adv = 1'b1;
                    if (i_sts.last_mark) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ACS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid,
        "input taken while a result is shown")
    `ACS_ASSERT_NEXT(a_exec_after_load, i_clk, i_rst_n, o_cmd.load, r_state == S_EXEC,
        "load not followed by execute")
    `ACS_ASSERT_IMP(a_mark_sel, i_clk, i_rst_n, o_cmd.mark_adv, o_cmd.emit_sel,
        "mark advance outside mark phase")

endmodule

// ===== rtl/arabic_contextual_shaper_core.sv =====
// Arabic contextual shaper core.
// Input channel (in): one Unicode code point per transaction with a
// string_end flag on the final point of the string. Output channel (out):
// shaped points with run_end on the last result of an input transaction,
// string_done on the last result of the string and marks_dropped when a
// mark of the string was lost for lack of buffer room.
// One transaction is in flight at a time: accept, an execute state and a
// state for the mark store read, then one result per cycle while out.ready
// is high. A point with no result (a mark buffered behind a waiting letter)
// goes straight back to idle after the read state.
// Dual-joining and join-causing points are held until the next non-transparent point.
// The rate is set by the controller sequencing results out of the mark store.
// Reset clears the waiting letter, the mark count and the overflow flag;
// the mark store itself is not cleared. A stalled receiver holds the result
// and blocks new input.
module arabic_contextual_shaper_core #(
    parameter int MARK_SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acs_in_if.sink    in,
    acs_out_if.source out
);

    acs_pkg::t_cmd cmd;
    acs_pkg::t_sts sts;

    acs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in.valid),
        .o_in_ready  (in.ready),
        .o_out_valid (out.valid),
        .i_out_ready (out.ready),
        .o_run_end   (out.run_end),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    logic dp_end;

    acs_datapath #(.MARK_SLOTS(MARK_SLOTS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code_point (in.code_point),
        .i_string_end (in.string_end),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_point      (out.shaped_point),
        .o_end        (dp_end),
        .o_dropped    (out.marks_dropped)
    );

    assign out.string_done = dp_end && out.run_end;

endmodule

// ===== test/testbench.sv =====
module testbench;
    typedef acs_pkg::t_cp t_cp;

    typedef struct {
        t_cp  cp;
        logic last;
        logic wait_empty;
    } t_text_item;

    typedef struct {
        t_cp  cp;
        logic run_end;
        logic string_done;
        logic dropped;
    } t_shaped;

    localparam int MARK_ROOM  = 8;
    localparam int STALL_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n;

    acs_in_if  in_ch ();
    acs_out_if out_ch ();

    arabic_contextual_shaper_core #(.MARK_SLOTS(MARK_ROOM)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in     (in_ch),
        .out    (out_ch)
    );

    t_text_item text_q[$];
    t_shaped    shaped_q[$];
    int         errors;
    int         points_taken;
    int         results_seen;
    logic       point_took;

    // predictor state
    logic       wait_valid;
    t_cp        wait_cp;
    logic       wait_joined;
    logic       prev_joins;
    t_cp        marks[MARK_ROOM];
    int         mark_cnt;
    logic       lost_marks;
    t_cp        step_out[$];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    function automatic logic is_combining(t_cp c);
        return (c >= 21'h0591 && c <= 21'h05BD) || c == 21'h05BF || c == 21'h05C1
            || c == 21'h05C2 || c == 21'h05C4 || c == 21'h05C5 || c == 21'h05C7
            || (c >= 21'h064B && c <= 21'h065F) || c == 21'h0670
            || (c >= 21'h06D6 && c <= 21'h06DC) || (c >= 21'h06DF && c <= 21'h06E4)
            || c == 21'h06E7 || c == 21'h06E8 || (c >= 21'h06EA && c <= 21'h06ED)
            || (c >= 21'h08D3 && c <= 21'h08FF) || (c >= 21'hFE70 && c <= 21'hFE7F);
    endfunction

    function automatic logic joins_right_only(t_cp c);
        case (c)
            21'h0622, 21'h0623, 21'h0624, 21'h0625, 21'h0627, 21'h0629, 21'h062F,
            21'h0630, 21'h0631, 21'h0632, 21'h0648, 21'h0649, 21'h0671, 21'h0672,
            21'h0673, 21'h0675, 21'h06C0, 21'h06D2, 21'h06D3, 21'h06D5:
                return 1'b1;
            default:
                return c >= 21'h0688 && c <= 21'h0699;
        endcase
    endfunction

    function automatic logic [2:0] join_class(t_cp c);
        if ((c >= 21'hFB50 && c <= 21'hFDFF) || (c >= 21'hFE70 && c <= 21'hFEFF))
            return acs_pkg::J_U;
        if (is_combining(c))
            return acs_pkg::J_T;
        if (c == acs_pkg::CP_ZWNJ)
            return acs_pkg::J_U;
        if (c == acs_pkg::CP_ZWJ || c == acs_pkg::CP_TATWEEL)
            return acs_pkg::J_C;
        if (c < acs_pkg::CP_HAMZA || c > acs_pkg::CP_AE) begin
            if ((c >= 21'h0750 && c <= 21'h077F) || (c >= 21'h08A0 && c <= 21'h08D2))
                return acs_pkg::J_D;
            return acs_pkg::J_U;
        end
        if (c == acs_pkg::CP_HAMZA)
            return acs_pkg::J_U;
        if (joins_right_only(c))
            return acs_pkg::J_R;
        return acs_pkg::J_D;
    endfunction

    // number of presentation forms per letter of the basic block
    function automatic int forms_per_letter(int idx);
        case (idx)
            0: return 1;
            1, 2, 3, 4, 6, 8, 14, 15, 16, 17, 39, 40: return 2;
            26, 27, 28, 29, 30, 31: return 0;
            default: return 4;
        endcase
    endfunction

    // f: 0 isolated, 1 final, 2 initial, 3 medial
    function automatic t_cp form_of(t_cp c, logic [1:0] f);
        int idx;
        int n;
        int j;
        t_cp base;
        t_cp v;
        v = '0;
        if (c >= acs_pkg::CP_HAMZA && c <= acs_pkg::CP_YEH) begin
            idx = int'(c - acs_pkg::CP_HAMZA);
            base = acs_pkg::FORM_BASE;
            for (j = 0; j < idx; j++)
                base = base + t_cp'(forms_per_letter(j));
            n = forms_per_letter(idx);
            if (n == 4)
                v = base + t_cp'(f);
            else if (n == 2)
                v = (f == 2'd1) ? base + 21'd1 : base;
            else if (n == 1)
                v = base;
        end else begin
            n = 4;
            case (c)
                21'h067E: base = 21'hFB56;
                21'h0686: base = 21'hFB7A;
                21'h0698: begin base = 21'hFB8A; n = 2; end
                21'h06A9: base = 21'hFB8E;
                21'h06AF: base = 21'hFB92;
                21'h06CC: base = 21'hFBFC;
                default: base = '0;
            endcase
            if (base != '0)
                v = (n == 4 || f == 2'd1) ? base + t_cp'(f) : base;
        end
        return (v != '0) ? v : c;
    endfunction

    function automatic t_cp lam_alef(t_cp alef, logic joined);
        t_cp b;
        case (alef)
            21'h0622: b = 21'hFEF5;
            21'h0623: b = 21'hFEF7;
            21'h0625: b = 21'hFEF9;
            21'h0627: b = 21'hFEFB;
            default: return '0;
        endcase
        return joined ? b + 21'd1 : b;
    endfunction

    task automatic settle_waiting(input logic joins_next, input t_cp nxt, output logic merged);
        t_cp lig;
        int  k;
        lig = lam_alef(nxt, wait_joined);
        merged = 1'b0;
        if (wait_cp == acs_pkg::CP_LAM && joins_next && lig != '0) begin
            step_out = {step_out, lig};
            prev_joins = 1'b0;
            merged = 1'b1;
        end else begin
            step_out = {step_out, form_of(wait_cp, {joins_next, wait_joined})};
            prev_joins = 1'b1;
        end
        for (k = 0; k < mark_cnt; k++)
            step_out = {step_out, marks[k]};
        mark_cnt = 0;
        wait_valid = 1'b0;
        wait_cp = '0;
        wait_joined = 1'b0;
    endtask

    task automatic shape_point(input t_cp c, input logic last);
        logic [2:0] cls;
        logic       merged;
        logic       drop_now;
        t_shaped    r;
        int         k;
        cls = join_class(c);
        merged = 1'b0;
        step_out.delete();
        if (cls == acs_pkg::J_T) begin
            if (wait_valid) begin
                if (mark_cnt < MARK_ROOM) begin
                    marks[mark_cnt] = c;
                    mark_cnt++;
                end else begin
                    lost_marks = 1'b1;
                end
                if (last)
                    settle_waiting(1'b0, '0, merged);
            end else begin
                step_out = {step_out, c};
            end
        end else begin
            if (wait_valid)
                settle_waiting(cls != acs_pkg::J_U, c, merged);
            if (!merged) begin
                if (cls == acs_pkg::J_U) begin
                    step_out = {step_out, form_of(c, 2'd0)};
                    prev_joins = 1'b0;
                end else if (cls == acs_pkg::J_R) begin
                    step_out = {step_out, form_of(c, {1'b0, prev_joins})};
                    prev_joins = 1'b0;
                end else if (last) begin
                    step_out = {step_out, form_of(c, {1'b0, prev_joins})};
                    prev_joins = 1'b1;
                end else begin
                    wait_valid = 1'b1;
                    wait_cp = c;
                    wait_joined = prev_joins;
                end
            end
        end
        drop_now = lost_marks;
        if (last) begin
            wait_valid = 1'b0;
            wait_cp = '0;
            wait_joined = 1'b0;
            prev_joins = 1'b0;
            mark_cnt = 0;
            lost_marks = 1'b0;
        end
        for (k = 0; k < step_out.size(); k++) begin
            r.cp = step_out[k];
            r.run_end = (k == step_out.size() - 1);
            r.string_done = r.run_end && last;
            r.dropped = drop_now;
            shaped_q = {shaped_q, r};
        end
    endtask

    task automatic report_mismatch(input string what, input t_cp got, input t_cp want);
        errors++;
        $display("mismatch: %s got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    task automatic add_point(input t_cp c, input logic last, input logic hold = 1'b0);
        t_text_item it;
        it.cp = c;
        it.last = last;
        it.wait_empty = hold;
        text_q = {text_q, it};
    endtask

    function automatic t_cp pick_mark();
        case ($urandom_range(0, 4))
            0: return t_cp'($urandom_range(21'h064B, 21'h065F));
            1: return t_cp'($urandom_range(21'h0591, 21'h05BD));
            2: return t_cp'($urandom_range(21'h08D3, 21'h08FF));
            3: return t_cp'($urandom_range(21'h06D6, 21'h06DC));
            default: return 21'h0670;
        endcase
    endfunction

    function automatic t_cp pick_letter();
        case ($urandom_range(0, 13))
            0, 1, 2: return t_cp'($urandom_range(21'h0621, 21'h064A));
            3: return acs_pkg::CP_LAM;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 21'h0622;
                    1: return 21'h0623;
                    2: return 21'h0625;
                    default: return 21'h0627;
                endcase
            end
            5: begin
                case ($urandom_range(0, 5))
                    0: return 21'h067E;
                    1: return 21'h0686;
                    2: return 21'h0698;
                    3: return 21'h06A9;
                    4: return 21'h06AF;
                    default: return 21'h06CC;
                endcase
            end
            6: return t_cp'($urandom_range(21'h0650, 21'h06D5));
            7: return ($urandom_range(0, 1) != 0) ? t_cp'($urandom_range(21'h0750, 21'h077F))
                                                  : t_cp'($urandom_range(21'h08A0, 21'h08D2));
            8: begin
                case ($urandom_range(0, 2))
                    0: return acs_pkg::CP_ZWJ;
                    1: return acs_pkg::CP_TATWEEL;
                    default: return acs_pkg::CP_ZWNJ;
                endcase
            end
            9: return t_cp'($urandom_range(21'hFB50, 21'hFEFF));
            10: return t_cp'($urandom_range(21'h20, 21'h7E));
            11: return t_cp'($urandom_range(0, 21'h1FFFFF));
            default: return t_cp'($urandom_range(0, 21'h10FFFF));
        endcase
    endfunction

    initial begin
        int letters;
        int nm;
        int i;
        int j;
        int n_items;

        errors = 0;
        points_taken = 0;
        results_seen = 0;
        point_took = 1'b0;
        wait_valid = 1'b0;
        wait_cp = '0;
        wait_joined = 1'b0;
        prev_joins = 1'b0;
        mark_cnt = 0;
        lost_marks = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.code_point = '0;
        in_ch.string_end = 1'b0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;

        // directed strings
        add_point(21'h000000, 1'b0);
        add_point(21'h1FFFFF, 1'b0);
        add_point(21'h10FFFF, 1'b0);
        add_point(21'h00D800, 1'b1);
        add_point(21'h00064E, 1'b0);          // mark with nothing waiting
        add_point(21'h000628, 1'b0);          // beh waits
        add_point(21'h00064E, 1'b0);
        add_point(acs_pkg::CP_LAM, 1'b0);
        add_point(21'h000651, 1'b0);
        add_point(21'h000627, 1'b0);          // lam-alef, joined
        add_point(acs_pkg::CP_ZWJ, 1'b0);
        add_point(21'h00067E, 1'b0);
        add_point(acs_pkg::CP_ZWNJ, 1'b0);
        add_point(acs_pkg::CP_TATWEEL, 1'b0);
        add_point(21'h00FB50, 1'b0);
        add_point(21'h00FEFF, 1'b1);
        add_point(acs_pkg::CP_LAM, 1'b0, 1'b1);
        for (i = 0; i < 10; i++)              // overflow the mark buffer
            add_point(21'h00064B + t_cp'(i), 1'b0);
        add_point(21'h000622, 1'b0);
        add_point(21'h0006CC, 1'b0);
        add_point(21'h000650, 1'b1);          // end on a mark with a letter waiting

        n_items = 0;
        while (n_items < 320) begin
            letters = $urandom_range(1, 7);
            for (i = 0; i < letters; i++) begin
                if ($urandom_range(0, 5) == 0) begin
                    add_point(acs_pkg::CP_LAM, 1'b0);
                    add_point(($urandom_range(0, 1) != 0) ? 21'h0627 : 21'h0623, 1'b0);
                    n_items += 2;
                end else begin
                    add_point(pick_letter(), 1'b0, $urandom_range(0, 60) == 0);
                    n_items++;
                end
                nm = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 11)
                                                  : (($urandom_range(0, 2) == 0)
                                                     ? $urandom_range(1, 2) : 0);
                for (j = 0; j < nm; j++) begin
                    add_point(pick_mark(), 1'b0);
                    n_items++;
                end
            end
            text_q[$].last = 1'b1;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (text_q.size() == 0 && in_ch.valid === 1'b0);
        wait (shaped_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && shaped_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // input side: predict on each accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            shape_point(in_ch.code_point, in_ch.string_end);
            points_taken++;
            point_took = 1'b1;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || point_took)) begin
            point_took = 1'b0;
            if (text_q.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (text_q[0].wait_empty && shaped_q.size() != 0) begin
                in_ch.valid <= 1'b0;
            end else if (!(points_taken >= 180 && points_taken < 260)
                         && $urandom_range(0, 99) < 22) begin
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.code_point <= text_q[0].cp;
                in_ch.string_end <= text_q[0].last;
                in_ch.valid <= 1'b1;
                void'(text_q.pop_front());
            end
        end
    end

    // receiver with one long hold-off
    int   hold_left = 0;
    logic hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && points_taken >= 120) begin
                hold_done <= 1'b1;
                hold_left <= 80;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (points_taken >= 180 && points_taken < 260) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_shaped want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (shaped_q.size() == 0) begin
                report_mismatch("unexpected result", out_ch.shaped_point, '0);
            end else begin
                want = shaped_q.pop_front();
                if (out_ch.shaped_point !== want.cp)
                    report_mismatch("shaped_point", out_ch.shaped_point, want.cp);
                if (out_ch.run_end !== want.run_end)
                    report_mismatch("run_end", t_cp'(out_ch.run_end), t_cp'(want.run_end));
                if (out_ch.string_done !== want.string_done)
                    report_mismatch("string_done", t_cp'(out_ch.string_done),
                                    t_cp'(want.string_done));
                if (out_ch.marks_dropped !== want.dropped)
                    report_mismatch("marks_dropped", t_cp'(out_ch.marks_dropped),
                                    t_cp'(want.dropped));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
